// File: sv/i2cbe_pkg.sv
package i2cbe_pkg;

  // command codes carried by the func field
  typedef enum logic [2:0] {
    FUNC_NONE    = 3'd0,
    FUNC_START   = 3'd1,
    FUNC_STOP    = 3'd2,
    FUNC_SEND    = 3'd3,
    FUNC_RECEIVE = 3'd4,
    FUNC_RECOVER = 3'd5,
    FUNC_PROBE   = 3'd6
  } func_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SETUP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACK   = 2'd2;

  localparam logic [7:0] SETUP_RESET = 8'd2;
  localparam logic [7:0] HALF_RESET  = 8'd5;
  localparam logic [7:0] ACK_RESET   = 8'd4;

  localparam logic [5:0] BYTE_BITS = 6'd8;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    ST_SETUP  = 5'd1,
    ST_HIGH   = 5'd2,
    ST_LOW    = 5'd3,
    SP_SETUP  = 5'd4,
    SP_HIGH   = 5'd5,
    SP_REL    = 5'd6,
    TX_LOW    = 5'd7,
    TX_HIGH   = 5'd8,
    TX_GAP    = 5'd9,
    TX_REL    = 5'd10,
    TX_ACKH   = 5'd11,
    TX_TAIL   = 5'd12,
    RX_HIGH   = 5'd13,
    RX_LOW    = 5'd14,
    RX_ACK    = 5'd15,
    RX_ACKH   = 5'd16,
    RC_LOW0   = 5'd17,
    RC_HIGH   = 5'd18,
    RC_LOW    = 5'd19,
    PB_SETUP  = 5'd20,
    PB_HIGH   = 5'd21,
    PB_REL    = 5'd22,
    PB_SETTLE = 5'd23,
    PB_CHECK  = 5'd24
  } phase_e;

  typedef struct packed {
    logic [7:0] setup_ticks;
    logic [7:0] half_ticks;
    logic [7:0] ack_ticks;
  } cfg_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       nack;
    logic [4:0] probe_left;
  } res_t;

endpackage

// File: sv/i2cbe_cfg.sv
module i2cbe_cfg import i2cbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setup_ticks <= SETUP_RESET;
      cfg_q.half_ticks  <= HALF_RESET;
      cfg_q.ack_ticks   <= ACK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SETUP: cfg_q.setup_ticks <= cfg_data_i;
        CFG_HALF:  cfg_q.half_ticks  <= cfg_data_i;
        CFG_ACK:   cfg_q.ack_ticks   <= cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/i2cbe_seq.sv
module i2cbe_seq import i2cbe_pkg::*; #(
  parameter int unsigned RECOVER_CLOCKS = 16,
  parameter int unsigned PROBE_CHECKS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [2:0] func_i,
  input  logic [7:0] tx_byte_i,
  input  logic       send_ack_i,
  input  logic       sda_in_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  localparam logic [5:0] RecLimit   = 6'(RECOVER_CLOCKS);
  localparam logic [4:0] ProbeStart = 5'(PROBE_CHECKS);

  phase_e     phase_q, phase_d;
  logic [7:0] wait_q, wait_d;
  logic [4:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic       scl_q, scl_d, sda_q, sda_d, ackc_q, ackc_d;
  logic [7:0] rx_q, rx_d;
  logic       nack_q, nack_d;
  logic [4:0] probe_q, probe_d;

  logic       idle, leave, done;
  logic [5:0] bit_inc;
  logic       tx_more, rx_more, rc_more, pb_end;
  logic [7:0] load_ticks, raw_ticks;

  assign idle    = (phase_q == PH_IDLE);
  assign leave   = !idle && (wait_q <= 8'd1);
  assign bit_inc = {1'b0, bit_q} + 6'd1;
  assign tx_more = bit_inc < BYTE_BITS;
  assign rx_more = bit_inc < BYTE_BITS;
  assign rc_more = bit_inc < RecLimit;
  assign pb_end  = !sda_in_i || (bit_q <= 5'd1);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (idle) begin
      unique case (func_i)
        FUNC_START:   phase_d = ST_SETUP;
        FUNC_STOP:    phase_d = SP_SETUP;
        FUNC_SEND:    phase_d = TX_LOW;
        FUNC_RECEIVE: phase_d = RX_HIGH;
        FUNC_RECOVER: phase_d = RC_LOW0;
        FUNC_PROBE:   phase_d = PB_SETUP;
        default:      phase_d = PH_IDLE;
      endcase
    end else if (leave) begin
      unique case (phase_q)
        ST_SETUP:  phase_d = ST_HIGH;
        ST_HIGH:   phase_d = ST_LOW;
        SP_SETUP:  phase_d = SP_HIGH;
        SP_HIGH:   phase_d = SP_REL;
        TX_LOW:    phase_d = TX_HIGH;
        TX_HIGH:   phase_d = tx_more ? TX_LOW : TX_GAP;
        TX_GAP:    phase_d = TX_REL;
        TX_REL:    phase_d = TX_ACKH;
        TX_ACKH:   phase_d = TX_TAIL;
        RX_HIGH:   phase_d = RX_LOW;
        RX_LOW:    phase_d = rx_more ? RX_HIGH : RX_ACK;
        RX_ACK:    phase_d = RX_ACKH;
        RC_LOW0:   phase_d = RC_HIGH;
        RC_HIGH:   phase_d = RC_LOW;
        RC_LOW:    phase_d = rc_more ? RC_HIGH : SP_SETUP;
        PB_SETUP:  phase_d = PB_HIGH;
        PB_HIGH:   phase_d = PB_REL;
        PB_REL:    phase_d = PB_SETTLE;
        PB_SETTLE: phase_d = PB_CHECK;
        PB_CHECK:  phase_d = pb_end ? PH_IDLE : PB_CHECK;
        default:   phase_d = PH_IDLE;  // end of command or stray code
      endcase
    end
  end

  assign done = leave && (phase_d == PH_IDLE);

  // delay loaded on entry depends only on the phase entered
  always_comb begin
    unique case (phase_d)
      ST_SETUP, SP_SETUP, PB_SETUP:             raw_ticks = cfg_i.setup_ticks;
      TX_TAIL, RX_ACK, RX_ACKH, PB_SETTLE:      raw_ticks = cfg_i.ack_ticks;
      default:                                  raw_ticks = cfg_i.half_ticks;
    endcase
    load_ticks = (raw_ticks == 8'd0) ? 8'd1 : raw_ticks;
  end

  always_comb begin
    if (idle && phase_d == PH_IDLE) begin
      wait_d = wait_q;
    end else if (idle || leave) begin
      wait_d = (phase_d == PH_IDLE) ? 8'd0 : load_ticks;
    end else begin
      wait_d = wait_q - 8'd1;
    end
  end

  // line drives and data path
  always_comb begin
    bit_d   = bit_q;
    shift_d = shift_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ackc_d  = ackc_q;
    rx_d    = rx_q;
    nack_d  = nack_q;
    probe_d = probe_q;
    if (idle) begin
      unique case (func_i)
        FUNC_START: sda_d = 1'b1;
        FUNC_STOP:  sda_d = 1'b0;
        FUNC_SEND: begin
          sda_d   = tx_byte_i[7];
          shift_d = {tx_byte_i[6:0], 1'b0};
          bit_d   = 5'd0;
          scl_d   = 1'b0;
        end
        FUNC_RECEIVE: begin
          ackc_d  = send_ack_i;
          sda_d   = 1'b1;
          shift_d = 8'd0;
          bit_d   = 5'd0;
          scl_d   = 1'b1;
        end
        FUNC_RECOVER: begin
          scl_d = 1'b0;
          bit_d = 5'd0;
        end
        FUNC_PROBE: sda_d = 1'b0;
        default: ;
      endcase
    end else if (leave) begin
      unique case (phase_q)
        ST_SETUP, SP_SETUP, TX_LOW, TX_REL, RC_LOW0, PB_SETUP: scl_d = 1'b1;
        ST_LOW, SP_REL, RC_HIGH: scl_d = 1'b0;
        ST_HIGH: sda_d = 1'b0;
        SP_HIGH, TX_GAP, PB_HIGH: sda_d = 1'b1;
        TX_HIGH: begin
          scl_d = 1'b0;
          if (tx_more) begin
            bit_d   = bit_inc[4:0];
            sda_d   = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
          end
        end
        TX_ACKH: begin
          nack_d = sda_in_i;
          scl_d  = 1'b0;
        end
        RX_HIGH: begin
          shift_d = {shift_q[6:0], sda_in_i};
          scl_d   = 1'b0;
        end
        RX_LOW: begin
          if (rx_more) begin
            bit_d = bit_inc[4:0];
            scl_d = 1'b1;
          end else begin
            sda_d = !ackc_q;
          end
        end
        RX_ACK: scl_d = 1'b1;
        RX_ACKH: begin
          scl_d = 1'b0;
          sda_d = 1'b1;
          rx_d  = shift_q;
        end
        RC_LOW: begin
          if (rc_more) begin
            bit_d = bit_inc[4:0];
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b0;
          end
        end
        PB_REL: begin
          scl_d = 1'b0;
          sda_d = 1'b1;
        end
        PB_SETTLE: bit_d = ProbeStart;
        PB_CHECK: begin
          if (!sda_in_i) begin
            probe_d = bit_q;
          end else if (bit_q <= 5'd1) begin
            probe_d = 5'd0;
          end else begin
            bit_d = bit_q - 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wait_q  <= 8'd0;
      bit_q   <= 5'd0;
      shift_q <= 8'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ackc_q  <= 1'b0;
      rx_q    <= 8'd0;
      nack_q  <= 1'b0;
      probe_q <= 5'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ackc_q  <= ackc_d;
      rx_q    <= rx_d;
      nack_q  <= nack_d;
      probe_q <= probe_d;
    end
  end

  always_comb begin
    res_o.scl        = scl_d;
    res_o.sda        = sda_d;
    res_o.busy       = (phase_d != PH_IDLE);
    res_o.done       = done;
    res_o.rx_byte    = rx_d;
    res_o.nack       = nack_d;
    res_o.probe_left = probe_d;
  end

endmodule

// File: sv/i2c_master_bit_engine_core.sv
// I2C master bit engine: one tick transfer in, one result transfer out.
// Path: a tick taken into the input register is stepped through the
// sequencer into the result register, from where its result can be taken;
// throughput one tick per cycle while the result side does not stall, set
// by the combinational sequencer step between the two registers.
// Reset (rst_ni low, asynchronous): sequencer idle, both lines released,
// delays back to 2/5/4 ticks, held results cleared, pipeline empty.
module i2c_master_bit_engine_core import i2cbe_pkg::*; #(
  parameter int unsigned RECOVER_CLOCKS = 16,
  parameter int unsigned PROBE_CHECKS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  // tick channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               send_ack_i,
  input  logic               sda_in_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               scl_out_o,
  output logic               sda_out_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [7:0]         rx_byte_o,
  output logic               nack_seen_o,
  output logic [4:0]         probe_left_o
);

  cfg_t cfg;
  res_t res_d, res_q;

  // input register
  logic       in_valid_q;
  logic [2:0] func_q;
  logic [7:0] tx_byte_q;
  logic       send_ack_q, sda_in_q;
  logic       out_valid_q;

  logic out_ready;  // result register free or being drained this cycle
  logic step;       // tick in the input register is executed now
  logic in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_ready;
  // input register refills when empty or when its tick moves on
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q     <= func_i;
      tx_byte_q  <= tx_byte_i;
      send_ack_q <= send_ack_i;
      sda_in_q   <= sda_in_i;
    end
  end

  i2cbe_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sequencer state advances only when its tick transfer can complete
  i2cbe_seq #(
    .RECOVER_CLOCKS (RECOVER_CLOCKS),
    .PROBE_CHECKS   (PROBE_CHECKS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .func_i     (func_q),
    .tx_byte_i  (tx_byte_q),
    .send_ack_i (send_ack_q),
    .sda_in_i   (sda_in_q),
    .cfg_i      (cfg),
    .res_o      (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_out_o    = res_q.scl;
  assign sda_out_o    = res_q.sda;
  assign busy_res_o   = res_q.busy;
  assign done_res_o   = res_q.done;
  assign rx_byte_o    = res_q.rx_byte;
  assign nack_seen_o  = res_q.nack;
  assign probe_left_o = res_q.probe_left;

endmodule

// File: bench/i2cbe_line_checker.sv
module i2cbe_line_checker import i2cbe_pkg::*; #(
  parameter int unsigned RECOVER_CLOCKS = 16,
  parameter int unsigned PROBE_CHECKS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         func_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               send_ack_i,
  input  logic               sda_in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               scl_out_i,
  input  logic               sda_out_i,
  input  logic               busy_res_i,
  input  logic               done_res_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               nack_seen_i,
  input  logic [4:0]         probe_left_i,
  output logic               engine_busy_o,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);

  // own copy of the sequencer
  cfg_t       delays;
  phase_e     phase;
  logic [7:0] wait_cnt;
  logic [4:0] bit_idx;
  logic [7:0] shifter;
  logic       scl_q;
  logic       sda_q;
  logic       ack_pick;
  logic [7:0] rx_last;
  logic       nack_last;
  logic [4:0] probe_last;

  res_t        line_forecast[$];
  int unsigned mismatches;
  int unsigned seen;

  function automatic void hold_for(phase_e ph, logic [7:0] ticks);
    phase    = ph;
    wait_cnt = (ticks == 8'd0) ? 8'd1 : ticks;
  endfunction

  function automatic void shift_out();
    sda_q   = shifter[7];
    shifter = {shifter[6:0], 1'b0};
  endfunction

  function automatic void launch(logic [2:0] func, logic [7:0] tx, logic ack);
    case (func)
      FUNC_START: begin
        sda_q = 1'b1;
        hold_for(ST_SETUP, delays.setup_ticks);
      end
      FUNC_STOP: begin
        sda_q = 1'b0;
        hold_for(SP_SETUP, delays.setup_ticks);
      end
      FUNC_SEND: begin
        shifter = tx;
        bit_idx = '0;
        scl_q   = 1'b0;
        shift_out();
        hold_for(TX_LOW, delays.half_ticks);
      end
      FUNC_RECEIVE: begin
        ack_pick = ack;
        sda_q    = 1'b1;
        shifter  = '0;
        bit_idx  = '0;
        scl_q    = 1'b1;
        hold_for(RX_HIGH, delays.half_ticks);
      end
      FUNC_RECOVER: begin
        scl_q   = 1'b0;
        bit_idx = '0;
        hold_for(RC_LOW0, delays.half_ticks);
      end
      FUNC_PROBE: begin
        sda_q = 1'b0;
        hold_for(PB_SETUP, delays.setup_ticks);
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the command finishes on this tick
  function automatic bit leave_phase(logic sda);
    int unsigned n;
    leave_phase = 1'b0;
    n = bit_idx + 1;
    case (phase)
      ST_SETUP: begin scl_q = 1'b1; hold_for(ST_HIGH, delays.half_ticks); end
      ST_HIGH:  begin sda_q = 1'b0; hold_for(ST_LOW, delays.half_ticks); end
      ST_LOW:   begin scl_q = 1'b0; leave_phase = 1'b1; end
      SP_SETUP: begin scl_q = 1'b1; hold_for(SP_HIGH, delays.half_ticks); end
      SP_HIGH:  begin sda_q = 1'b1; hold_for(SP_REL, delays.half_ticks); end
      SP_REL:   begin scl_q = 1'b0; leave_phase = 1'b1; end
      TX_LOW:   begin scl_q = 1'b1; hold_for(TX_HIGH, delays.half_ticks); end
      TX_HIGH: begin
        scl_q = 1'b0;
        if (n < 8) begin
          bit_idx = 5'(n);
          shift_out();
          hold_for(TX_LOW, delays.half_ticks);
        end else begin
          hold_for(TX_GAP, delays.half_ticks);
        end
      end
      TX_GAP:  begin sda_q = 1'b1; hold_for(TX_REL, delays.half_ticks); end
      TX_REL:  begin scl_q = 1'b1; hold_for(TX_ACKH, delays.half_ticks); end
      TX_ACKH: begin
        nack_last = sda;
        scl_q     = 1'b0;
        hold_for(TX_TAIL, delays.ack_ticks);
      end
      TX_TAIL: leave_phase = 1'b1;
      RX_HIGH: begin
        shifter = {shifter[6:0], sda};
        scl_q   = 1'b0;
        hold_for(RX_LOW, delays.half_ticks);
      end
      RX_LOW: begin
        if (n < 8) begin
          bit_idx = 5'(n);
          scl_q   = 1'b1;
          hold_for(RX_HIGH, delays.half_ticks);
        end else begin
          sda_q = ~ack_pick;
          hold_for(RX_ACK, delays.ack_ticks);
        end
      end
      RX_ACK: begin scl_q = 1'b1; hold_for(RX_ACKH, delays.ack_ticks); end
      RX_ACKH: begin
        scl_q       = 1'b0;
        sda_q       = 1'b1;
        rx_last     = shifter;
        leave_phase = 1'b1;
      end
      RC_LOW0: begin scl_q = 1'b1; hold_for(RC_HIGH, delays.half_ticks); end
      RC_HIGH: begin scl_q = 1'b0; hold_for(RC_LOW, delays.half_ticks); end
      RC_LOW: begin
        if (n < RECOVER_CLOCKS) begin
          bit_idx = 5'(n);
          scl_q   = 1'b1;
          hold_for(RC_HIGH, delays.half_ticks);
        end else begin
          sda_q = 1'b0;
          hold_for(SP_SETUP, delays.setup_ticks);
        end
      end
      PB_SETUP: begin scl_q = 1'b1; hold_for(PB_HIGH, delays.half_ticks); end
      PB_HIGH:  begin sda_q = 1'b1; hold_for(PB_REL, delays.half_ticks); end
      PB_REL: begin
        scl_q = 1'b0;
        sda_q = 1'b1;
        hold_for(PB_SETTLE, delays.ack_ticks);
      end
      PB_SETTLE: begin
        bit_idx = 5'(PROBE_CHECKS);
        hold_for(PB_CHECK, delays.half_ticks);
      end
      PB_CHECK: begin
        if (!sda) begin
          probe_last  = bit_idx;
          leave_phase = 1'b1;
        end else if (bit_idx <= 5'd1) begin
          probe_last  = '0;
          leave_phase = 1'b1;
        end else begin
          bit_idx = bit_idx - 5'd1;
          hold_for(PB_CHECK, delays.half_ticks);
        end
      end
      default: leave_phase = 1'b1;
    endcase
  endfunction

  function automatic res_t tick_engine(logic [2:0] func, logic [7:0] tx, logic ack,
                                       logic sda);
    res_t r;
    logic fin;
    fin = 1'b0;
    if (phase == PH_IDLE) begin
      launch(func, tx, ack);
    end else if (wait_cnt > 8'd1) begin
      wait_cnt = wait_cnt - 8'd1;
    end else if (leave_phase(sda)) begin
      phase    = PH_IDLE;
      wait_cnt = '0;
      fin      = 1'b1;
    end
    r.scl        = scl_q;
    r.sda        = sda_q;
    r.busy       = (phase != PH_IDLE);
    r.done       = fin;
    r.rx_byte    = rx_last;
    r.nack       = nack_last;
    r.probe_left = probe_last;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    res_t got;
    res_t want;
    if (!rst_ni) begin
      delays     = '{SETUP_RESET, HALF_RESET, ACK_RESET};
      phase      = PH_IDLE;
      wait_cnt   = '0;
      bit_idx    = '0;
      shifter    = '0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      ack_pick   = 1'b0;
      rx_last    = '0;
      nack_last  = 1'b0;
      probe_last = '0;
      line_forecast.delete();
      mismatches = 0;
      seen       = 0;
      engine_busy_o <= 1'b0;
      pending_o     <= 0;
      fail_count_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{scl_out_i, sda_out_i, busy_res_i, done_res_i, rx_byte_i, nack_seen_i,
                probe_left_i};
        if (line_forecast.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with nothing expected", seen);
          mismatches++;
        end else begin
          want = line_forecast.pop_front();
          if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
              got.done !== want.done || got.rx_byte !== want.rx_byte ||
              got.nack !== want.nack || got.probe_left !== want.probe_left) begin
            if (mismatches < 10) begin
              $display("result %0d expected scl %b sda %b busy %b done %b rx %h nack %b probe %0d",
                       seen, want.scl, want.sda, want.busy, want.done, want.rx_byte,
                       want.nack, want.probe_left);
              $display("result %0d got      scl %b sda %b busy %b done %b rx %h nack %b probe %0d",
                       seen, got.scl, got.sda, got.busy, got.done, got.rx_byte,
                       got.nack, got.probe_left);
            end
            mismatches++;
          end
        end
        seen++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SETUP: delays.setup_ticks = cfg_data_i;
          CFG_HALF:  delays.half_ticks  = cfg_data_i;
          CFG_ACK:   delays.ack_ticks   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        line_forecast.push_back(tick_engine(func_i, tx_byte_i, send_ack_i, sda_in_i));
      engine_busy_o <= (phase != PH_IDLE);
      pending_o     <= line_forecast.size();
      fail_count_o  <= mismatches;
    end
  end

endmodule

// File: bench/i2c_master_bit_engine_core_test.sv
module i2c_master_bit_engine_core_test;
  import i2cbe_pkg::*;

  localparam int unsigned RECOVER_CLOCKS = 16;
  localparam int unsigned PROBE_CHECKS   = 16;
  // index 3 has no register behind it, writes there must be dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  // selector 7 has no command and is treated as no command
  localparam logic [2:0] FUNC_SPARE = 3'd7;
  localparam int unsigned CHOKE_CYCLES = 120;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 4;    // two-stage pipe plus margin

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [7:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         func_i;
  logic [7:0]         tx_byte_i;
  logic               send_ack_i;
  logic               sda_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               scl_out_o;
  logic               sda_out_o;
  logic               busy_res_o;
  logic               done_res_o;
  logic [7:0]         rx_byte_o;
  logic               nack_seen_o;
  logic [4:0]         probe_left_o;

  logic        engine_busy;
  int unsigned pending;
  int unsigned fail_count;

  // sender burst state and the modelled SDA line
  int unsigned burst_left = 0;
  int unsigned sda_churn  = 0;   // 0 holds the line, n flips it about 1 tick in n
  logic        sda_line   = 1'b1;
  bit          choke_req  = 1'b0;
  bit          choke_done = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  i2c_master_bit_engine_core #(
    .RECOVER_CLOCKS(RECOVER_CLOCKS),
    .PROBE_CHECKS  (PROBE_CHECKS)
  ) DUT (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .tx_byte_i, .send_ack_i, .sda_in_i,
    .out_valid_o, .out_stall_i, .scl_out_o, .sda_out_o, .busy_res_o, .done_res_o,
    .rx_byte_o, .nack_seen_o, .probe_left_o
  );

  i2cbe_line_checker #(
    .RECOVER_CLOCKS(RECOVER_CLOCKS),
    .PROBE_CHECKS  (PROBE_CHECKS)
  ) watch (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .tx_byte_i, .send_ack_i, .sda_in_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .scl_out_i(scl_out_o), .sda_out_i(sda_out_o), .busy_res_i(busy_res_o),
    .done_res_i(done_res_o), .rx_byte_i(rx_byte_o), .nack_seen_i(nack_seen_o),
    .probe_left_i(probe_left_o),
    .engine_busy_o(engine_busy), .pending_o(pending), .fail_count_o(fail_count)
  );

  function automatic logic next_sda();
    if (sda_churn != 0 && $urandom_range(1, sda_churn) == 1) sda_line = ~sda_line;
    return sda_line;
  endfunction

  // One tick transfer. Valid stays up through a burst; between bursts it
  // drops for a short random gap.
  task automatic put_tick(input logic [2:0] f, input logic [7:0] tx, input logic ack);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 240)
                                               : $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    tx_byte_i  <= tx;
    send_ack_i <= ack;
    sda_in_i   <= next_sda();
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    burst_left--;
  endtask

  // Idle ticks until the engine is back in idle. The checker's busy flag is
  // updated after the edge, so at each accepting edge it describes the tick
  // before; when that one left the engine idle, the none tick just taken
  // leaves it idle as well.
  task automatic settle();
    do begin
      put_tick(FUNC_NONE, 8'($urandom), 1'($urandom));
    end while (engine_busy);
  endtask

  task automatic run_cmd(input logic [2:0] f, input logic [7:0] tx, input logic ack);
    put_tick(f, tx, ack);
    settle();
  endtask

  // engine idle and every result out: safe to touch the delay registers
  task automatic quiesce();
    settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // one write per cycle, write enable held across the run of writes
  task automatic write_delays(input logic [7:0] s, input logic [7:0] h,
                              input logic [7:0] a);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SETUP;
    cfg_data_i <= s;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HALF;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ACK;
    cfg_data_i <= a;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SPARE;
    cfg_data_i <= 8'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Random ticks: commands land on about four ticks in ten, all selectors including
  // the spare one; commands offered while busy must be ignored. The SDA line
  // switches between held, slowly wandering and noisy every 50 ticks so
  // that probes see both a free and a held bus.
  task automatic random_ticks(input int unsigned count);
    int unsigned k;
    logic [2:0]  f;
    for (k = 0; k < count; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       sda_churn = 0;
          1:       sda_churn = 2;
          2:       sda_churn = 8;
          default: sda_churn = 40;
        endcase
      end
      if ($urandom_range(0, 9) < 6) f = FUNC_NONE;
      else                          f = 3'($urandom_range(1, 7));
      put_tick(f, 8'($urandom), 1'($urandom));
    end
  endtask

  // Result side: stretches of no stall, random stall and a fixed pattern;
  // once, on request, a long hold-off so that the pipe fills and the input
  // side stalls while ticks are still offered.
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (k = 0; k < span; k++) begin
        @(posedge clk_i);
        if (choke_req && !choke_done) begin
          out_stall_i <= 1'b1;
          repeat (CHOKE_CYCLES) @(posedge clk_i);
          choke_done = 1'b1;
        end
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= (k % 4 == 3);
          default: out_stall_i <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned p;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_SETUP;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_NONE;
    tx_byte_i   <= '0;
    send_ack_i  <= 1'b0;
    sda_in_i    <= 1'b1;
    out_stall_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset delays
    sda_churn = 0;
    sda_line  = 1'b1;
    run_cmd(FUNC_START, 8'h00, 1'b0);
    run_cmd(FUNC_SEND, 8'hFF, 1'b0);     // SDA left high: acknowledge reads NACK
    sda_line = 1'b0;
    run_cmd(FUNC_SEND, 8'h00, 1'b1);     // SDA pulled low: ACK
    sda_churn = 2;
    run_cmd(FUNC_RECEIVE, 8'h5A, 1'b1);  // master drives ACK
    run_cmd(FUNC_RECEIVE, 8'hA5, 1'b0);  // master leaves NACK
    run_cmd(FUNC_STOP, 8'hFF, 1'b1);
    put_tick(FUNC_SPARE, 8'hC3, 1'b1);   // unused selector, nothing starts
    put_tick(FUNC_NONE, 8'h3C, 1'b0);    // idle tick, drives keep their level
    // a start, then further commands while busy, which are dropped
    put_tick(FUNC_START, 8'h11, 1'b0);
    put_tick(FUNC_STOP, 8'h22, 1'b1);
    put_tick(FUNC_SEND, 8'h33, 1'b0);
    put_tick(FUNC_PROBE, 8'h44, 1'b1);
    settle();
    run_cmd(FUNC_RECOVER, 8'h00, 1'b0);
    sda_churn = 0;
    sda_line  = 1'b1;
    run_cmd(FUNC_PROBE, 8'h00, 1'b0);    // bus free: no check sees SDA low
    sda_line = 1'b0;
    run_cmd(FUNC_PROBE, 8'h00, 1'b0);    // bus held: first check sees SDA low
    sda_line  = 1'b1;
    sda_churn = 30;
    run_cmd(FUNC_PROBE, 8'h00, 1'b0);    // SDA drops somewhere in the checks

    // all delays zero, which must act as one tick; squeeze the pipe here
    quiesce();
    write_delays(8'd0, 8'd0, 8'd0);
    choke_req = 1'b1;
    random_ticks(100);

    for (p = 0; p < 2; p++) begin
      quiesce();
      write_delays(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                   8'($urandom_range(1, 4)));
      random_ticks(100);
    end

    // largest setup delay, one start only
    quiesce();
    write_delays(8'd255, 8'd1, 8'd1);
    sda_churn = 6;
    run_cmd(FUNC_START, 8'h00, 1'b0);

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
